[hw/rtl/assert_macros.svh]
// assertion helpers used by the top-level rtl file
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PBDR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBDR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pbdr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdr_pkg
// types, codes and defaults shared by the palette blitter files
// ----------------------------------------------------------------------------
package pbdr_pkg;

  localparam int MAX_RECTS_DEF    = 200;
  localparam int PALETTE_SIZE_DEF = 256;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_MODE   = 2'd2;

  localparam logic [8:0] SCREEN_WIDTH_RST  = 9'd256;
  localparam logic [8:0] SCREEN_HEIGHT_RST = 9'd224;

  // rectangle status codes
  localparam logic [1:0] ST_RECORDED  = 2'd0;
  localparam logic [1:0] ST_LIST_FULL = 2'd1;
  localparam logic [1:0] ST_OFFSCREEN = 2'd2;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef enum logic [1:0] {
    FUNC_PAL_WR     = 2'd0,
    FUNC_RECT       = 2'd1,
    FUNC_PIXEL      = 2'd2,
    FUNC_FRAME_DONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CMD_PAL_WR = 2'd0,
    CMD_STATUS = 2'd1,
    CMD_PIXEL  = 2'd2
  } cmd_op_e;

  typedef struct packed {
    logic [8:0] screen_width;
    logic [8:0] screen_height;
    logic       mirror_mode;
  } cfg_t;

  // one queued command from the front to the back end
  typedef struct packed {
    cmd_op_e     op;
    logic [1:0]  status;
    logic [7:0]  out_x;
    logic [7:0]  out_y;
    logic [8:0]  out_w;
    logic [8:0]  out_h;
    logic [7:0]  rect_count;
    logic [7:0]  pix;
    logic [15:0] color;
    logic [9:0]  row1;
    logic [9:0]  colsum;
  } cmd_t;

  typedef struct packed {
    logic [7:0] dirty_count;
    logic       active;
    logic [8:0] cur_w;
    logic [8:0] cur_h;
  } front_stat_t;

endpackage

[hw/rtl/pbdr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdr_if
// valid/ready channels for blitter items and results
// ----------------------------------------------------------------------------
interface pbdr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  rect_x;
  logic [7:0]  rect_y;
  logic [8:0]  rect_w;
  logic [8:0]  rect_h;
  logic [7:0]  pal_index;
  logic [15:0] pal_color;
  logic [7:0]  src_pixel;

  modport source (
    output valid, func, rect_x, rect_y, rect_w, rect_h, pal_index, pal_color, src_pixel,
    input  ready
  );
  modport sink (
    input  valid, func, rect_x, rect_y, rect_w, rect_h, pal_index, pal_color, src_pixel,
    output ready
  );
endinterface

interface pbdr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  status;
  logic [7:0]  out_x;
  logic [7:0]  out_y;
  logic [8:0]  out_w;
  logic [8:0]  out_h;
  logic [7:0]  rect_count;
  logic [16:0] fb_addr;
  logic [15:0] fb_color;

  modport source (
    output valid, kind, status, out_x, out_y, out_w, out_h, rect_count, fb_addr, fb_color,
    input  ready
  );
  modport sink (
    input  valid, kind, status, out_x, out_y, out_w, out_h, rect_count, fb_addr, fb_color,
    output ready
  );
endinterface

[hw/rtl/pbdr_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdr_fifo
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
module pbdr_fifo #(
  parameter int DEPTH = pbdr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pbdr_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pbdr_pkg::cmd_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  pbdr_pkg::cmd_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/pbdr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdr_front
// accepts items, clips rectangles, walks the pixel stream, queues commands
// ----------------------------------------------------------------------------
module pbdr_front #(
  parameter int MAX_RECTS = pbdr_pkg::MAX_RECTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pbdr_in_if.sink               in_ch,
  input  pbdr_pkg::cfg_t        cfg_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output pbdr_pkg::cmd_t        q_cmd_o,
  output pbdr_pkg::front_stat_t stat_o
);

  logic [7:0] dirty_q, dirty_d;
  logic       active_q, active_d;
  logic [8:0] cur_x_q, cur_x_d;
  logic [8:0] cur_y_q, cur_y_d;
  logic [8:0] cur_w_q, cur_w_d;
  logic [8:0] cur_h_q, cur_h_d;
  logic [8:0] col_q, col_d;
  logic [8:0] row_q, row_d;

  logic             accept;
  pbdr_pkg::func_e  func;
  logic             list_full;
  logic [7:0]       x_c, y_c;
  logic             x_off, y_off;
  logic [9:0]       w_g, h_g;
  logic [10:0]      x_end, y_end;
  logic [8:0]       w_c, h_c;
  logic [8:0]       xw_c, rx;
  logic [8:0]       col;
  logic             col_last, row_last;

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign func        = pbdr_pkg::func_e'(in_ch.func);
  assign list_full   = (dirty_q >= 8'(MAX_RECTS));

  // grow by one pixel, clamp at top/left
  assign x_c   = (in_ch.rect_x == 8'd0) ? 8'd0 : in_ch.rect_x - 8'd1;
  assign y_c   = (in_ch.rect_y == 8'd0) ? 8'd0 : in_ch.rect_y - 8'd1;
  assign x_off = (in_ch.rect_x != 8'd0) && ({1'b0, x_c} >= cfg_i.screen_width);
  assign y_off = (in_ch.rect_y != 8'd0) && ({1'b0, y_c} >= cfg_i.screen_height);
  assign w_g   = {1'b0, in_ch.rect_w} + 10'd2;
  assign h_g   = {1'b0, in_ch.rect_h} + 10'd2;
  assign x_end = {3'b0, x_c} + {1'b0, w_g};
  assign y_end = {3'b0, y_c} + {1'b0, h_g};

  // clip right and bottom
  assign w_c  = (x_end > {2'b0, cfg_i.screen_width}) ? cfg_i.screen_width - {1'b0, x_c}
                                                     : w_g[8:0];
  assign h_c  = (y_end > {2'b0, cfg_i.screen_height}) ? cfg_i.screen_height - {1'b0, y_c}
                                                      : h_g[8:0];
  assign xw_c = {1'b0, x_c} + w_c;
  assign rx   = cfg_i.mirror_mode ? cfg_i.screen_width - xw_c : {1'b0, x_c};

  // pixel walk
  assign col      = cfg_i.mirror_mode ? cur_w_q - 9'd1 - col_q : col_q;
  assign col_last = ({1'b0, col_q} + 10'd1) >= {1'b0, cur_w_q};
  assign row_last = ({1'b0, row_q} + 10'd1) >= {1'b0, cur_h_q};

  always_comb begin
    dirty_d  = dirty_q;
    active_d = active_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    cur_w_d  = cur_w_q;
    cur_h_d  = cur_h_q;
    col_d    = col_q;
    row_d    = row_q;
    q_push_o = 1'b0;
    q_cmd_o  = '0;

    unique case (func)
      pbdr_pkg::FUNC_PAL_WR: begin
        q_push_o      = accept;
        q_cmd_o.op    = pbdr_pkg::CMD_PAL_WR;
        q_cmd_o.pix   = in_ch.pal_index;
        q_cmd_o.color = in_ch.pal_color;
      end
      pbdr_pkg::FUNC_FRAME_DONE: begin
        if (accept) begin
          dirty_d = '0;
        end
      end
      pbdr_pkg::FUNC_RECT: begin
        q_push_o   = accept;
        q_cmd_o.op = pbdr_pkg::CMD_STATUS;
        if (accept) begin
          active_d = 1'b0;
        end
        priority if (list_full) begin
          q_cmd_o.status     = pbdr_pkg::ST_LIST_FULL;
          q_cmd_o.rect_count = dirty_q;
        end else if (x_off || y_off) begin
          q_cmd_o.status     = pbdr_pkg::ST_OFFSCREEN;
          q_cmd_o.rect_count = dirty_q;
        end else begin
          q_cmd_o.status     = pbdr_pkg::ST_RECORDED;
          q_cmd_o.out_x      = rx[7:0];
          q_cmd_o.out_y      = y_c;
          q_cmd_o.out_w      = w_c;
          q_cmd_o.out_h      = h_c;
          q_cmd_o.rect_count = dirty_q + 8'd1;
          if (accept) begin
            dirty_d  = dirty_q + 8'd1;
            cur_x_d  = rx;
            cur_y_d  = {1'b0, y_c};
            cur_w_d  = w_c;
            cur_h_d  = h_c;
            col_d    = '0;
            row_d    = '0;
            active_d = (w_c != 9'd0) && (h_c != 9'd0);
          end
        end
      end
      pbdr_pkg::FUNC_PIXEL: begin
        if (active_q) begin
          q_push_o       = accept;
          q_cmd_o.op     = pbdr_pkg::CMD_PIXEL;
          q_cmd_o.pix    = in_ch.src_pixel;
          q_cmd_o.row1   = {1'b0, cur_y_q} + {1'b0, row_q} + 10'd1;
          q_cmd_o.colsum = {1'b0, cur_x_q} + {1'b0, col} + 10'd1;
          if (accept) begin
            if (col_last) begin
              col_d = '0;
              if (row_last) begin
                row_d    = '0;
                active_d = 1'b0;
              end else begin
                row_d = row_q + 9'd1;
              end
            end else begin
              col_d = col_q + 9'd1;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q  <= '0;
      active_q <= 1'b0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      cur_w_q  <= '0;
      cur_h_q  <= '0;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      dirty_q  <= dirty_d;
      active_q <= active_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      cur_w_q  <= cur_w_d;
      cur_h_q  <= cur_h_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  assign stat_o.dirty_count = dirty_q;
  assign stat_o.active      = active_q;
  assign stat_o.cur_w       = cur_w_q;
  assign stat_o.cur_h       = cur_h_q;

endmodule

[hw/rtl/pbdr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdr_back
// palette memory, address multiply and output register
// ----------------------------------------------------------------------------
module pbdr_back #(
  parameter int PALETTE_SIZE = pbdr_pkg::PALETTE_SIZE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  pbdr_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  input  logic [8:0]     screen_width_i,
  pbdr_out_if.source     out_ch
);

  localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

  logic [15:0]       pal_mem_q [PALETTE_SIZE];
  logic              pal_vld_q [PALETTE_SIZE];
  logic [IDX_W-1:0]  idx;
  logic              in_range, wr_en, rd_en, has_result;

  // stage 1: palette read and multiply
  logic        s1_valid_q, s1_valid_d;
  logic        s1_kind_q;
  logic [1:0]  s1_status_q;
  logic [7:0]  s1_x_q, s1_y_q, s1_count_q;
  logic [8:0]  s1_w_q, s1_h_q;
  logic [18:0] s1_prod_q, prod;
  logic [9:0]  s1_colsum_q;
  logic [15:0] s1_rdata_q;
  logic        s1_rvld_q;
  logic        s1_free;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        out_adv;

  assign idx        = q_cmd_i.pix[IDX_W-1:0];
  assign in_range   = ({1'b0, q_cmd_i.pix} < 9'(PALETTE_SIZE));
  assign out_adv    = !out_valid_q || out_ch.ready;
  assign s1_free    = !s1_valid_q || out_adv;
  assign q_pop_o    = q_valid_i && s1_free;
  assign has_result = (q_cmd_i.op != pbdr_pkg::CMD_PAL_WR);
  assign wr_en      = q_pop_o && !has_result && in_range;
  assign rd_en      = q_pop_o && (q_cmd_i.op == pbdr_pkg::CMD_PIXEL);
  assign prod       = {9'b0, q_cmd_i.row1} * {10'b0, screen_width_i};

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (s1_free) begin
      s1_valid_d = q_pop_o && has_result;
    end
    if (out_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // valid bits stand in for the cleared palette
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PALETTE_SIZE; i++) begin
        pal_vld_q[i] <= 1'b0;
      end
    end else if (wr_en) begin
      pal_vld_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pal_mem_q[idx] <= q_cmd_i.color;
    end
    if (rd_en) begin
      s1_rdata_q <= pal_mem_q[idx];
      s1_rvld_q  <= in_range && pal_vld_q[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && has_result) begin
      s1_kind_q   <= (q_cmd_i.op == pbdr_pkg::CMD_PIXEL) ? pbdr_pkg::KIND_PIXEL
                                                         : pbdr_pkg::KIND_STATUS;
      s1_status_q <= q_cmd_i.status;
      s1_x_q      <= q_cmd_i.out_x;
      s1_y_q      <= q_cmd_i.out_y;
      s1_w_q      <= q_cmd_i.out_w;
      s1_h_q      <= q_cmd_i.out_h;
      s1_count_q  <= q_cmd_i.rect_count;
      s1_prod_q   <= prod;
      s1_colsum_q <= q_cmd_i.colsum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_ch.kind       <= s1_kind_q;
      out_ch.status     <= s1_status_q;
      out_ch.out_x      <= s1_x_q;
      out_ch.out_y      <= s1_y_q;
      out_ch.out_w      <= s1_w_q;
      out_ch.out_h      <= s1_h_q;
      out_ch.rect_count <= s1_count_q;
      if (s1_kind_q == pbdr_pkg::KIND_PIXEL) begin
        out_ch.fb_addr  <= 17'(s1_prod_q + {9'b0, s1_colsum_q});
        out_ch.fb_color <= s1_rvld_q ? s1_rdata_q : 16'd0;
      end else begin
        out_ch.fb_addr  <= '0;
        out_ch.fb_color <= '0;
      end
    end
  end

  assign out_ch.valid = out_valid_q;

endmodule

[hw/rtl/palette_blit_dirty_rect.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_blit_dirty_rect
// indexed-color blitter with dirty-rectangle list, top level
// ----------------------------------------------------------------------------
// takes one item per clock, sustained, as long as results are taken; after its
// item transfers, a result passes through the queue entry, the palette read and
// row multiply, then the final add into the output register, and ready drops
// only when the four-entry command queue fills. the palette comes up all zero
// through per-entry valid bits, so there is no clearing pass after reset. the
// front end keeps the dirty count and the pixel walk, so rectangle, frame-done
// and pixel items resolve there; palette writes and pixel lookups stay in order
// through the queue, so a write is seen by every later pixel. configuration is
// written only while idle by the user; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_blit_dirty_rect #(
  parameter int MAX_RECTS    = pbdr_pkg::MAX_RECTS_DEF,
  parameter int PALETTE_SIZE = pbdr_pkg::PALETTE_SIZE_DEF,
  parameter int QUEUE_DEPTH  = pbdr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pbdr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pbdr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pbdr_in_if.sink                        in_ch,
  pbdr_out_if.source                     out_ch
);

  pbdr_pkg::cfg_t        cfg_q, cfg_d;
  pbdr_pkg::cmd_t        push_cmd, pop_cmd;
  pbdr_pkg::front_stat_t stat;
  logic                  q_push, q_full, q_valid, q_pop;

  // configuration registers, written only while idle by the user (not enforced)
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbdr_pkg::REG_SCREEN_WIDTH:  cfg_d.screen_width  = cfg_data_i;
        pbdr_pkg::REG_SCREEN_HEIGHT: cfg_d.screen_height = cfg_data_i;
        pbdr_pkg::REG_MIRROR_MODE:   cfg_d.mirror_mode   = cfg_data_i[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= pbdr_pkg::SCREEN_WIDTH_RST;
      cfg_q.screen_height <= pbdr_pkg::SCREEN_HEIGHT_RST;
      cfg_q.mirror_mode   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: classify, clip rectangles, step the pixel walk
  pbdr_front #(
    .MAX_RECTS (MAX_RECTS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (push_cmd),
    .stat_o   (stat)
  );

  // command queue decouples the two halves
  pbdr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (pop_cmd)
  );

  // back: palette access, framebuffer address, result transfer
  pbdr_back #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_cmd_i        (pop_cmd),
    .q_pop_o        (q_pop),
    .screen_width_i (cfg_q.screen_width),
    .out_ch         (out_ch)
  );

  // front never pushes into a full queue
  `PBDR_ASSERT_IMP(a_push_room, q_push, !q_full, "command pushed into full queue")
  // dirty list never grows past its limit
  `PBDR_ASSERT_IMP(a_dirty_bound, 1'b1, stat.dirty_count <= 8'(MAX_RECTS), "dirty count over limit")
  // an active stream always has a nonempty region
  `PBDR_ASSERT_IMP(a_active_dims, stat.active, (stat.cur_w != 9'd0) && (stat.cur_h != 9'd0),
    "active stream with empty region")
  // frame done empties the list
  `PBDR_ASSERT_NXT(a_frame_clear,
    in_ch.valid && in_ch.ready && (in_ch.func == pbdr_pkg::FUNC_FRAME_DONE),
    stat.dirty_count == 8'd0, "dirty list not cleared by frame done")

endmodule
